// File: src/sct_pkg.sv
// Shared types and constants for the sorted code table search block.
`default_nettype none

package sct_pkg;

   // Widths of the fields that travel on the ports.
   localparam int MODE_W  = 2;
   localparam int INDEX_W = 10;
   localparam int CODE_W  = 21;
   localparam int COUNT_W = 11;
   localparam int OFFS_W  = 14;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] entry_index;
      logic [CODE_W-1:0]  entry_code;
      logic [CODE_W-1:0]  search_code;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_position;
      logic [OFFS_W-1:0]  bitmap_offset;
      logic [CODE_W-1:0]  read_code;
      logic               out_of_range;
   } rsp_type;

   // Which result the datapath captures.
   typedef enum logic [1:0] {
      RES_ZERO = 2'd0,
      RES_OOR  = 2'd1,
      RES_READ = 2'd2,
      RES_HIT  = 2'd3
   } res_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         table_write;
      logic         init_search;
      logic         step_search;
      logic         res_load;
      res_kind_type res_kind;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_load;
      logic is_search;
      logic is_read;
      logic table_empty;
      logic read_oor;
      logic hit;
      logic more;
   } status_type;

endpackage

`default_nettype wire

// File: src/sct_dp.sv
// Datapath of the sorted code table search: code memory, search bounds and result register.
`default_nettype none

module sct_dp #(
   parameter int MAX_ENTRIES = 1024,
   parameter int GLYPH_WORDS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [sct_pkg::COUNT_W-1:0] csr_wr_data,
   input  wire sct_pkg::req_type            req_data,
   input  wire sct_pkg::cmd_type            cmd,
   output sct_pkg::status_type              status,
   output sct_pkg::rsp_type                 rsp_data
);

   localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int XW    = 17;
   localparam int CLAMP = (MAX_ENTRIES > 2047) ? 2047 : MAX_ENTRIES;
   localparam logic [sct_pkg::COUNT_W-1:0] CLAMP_C = sct_pkg::COUNT_W'(CLAMP);
   localparam logic [XW-1:0] MAX_C = XW'(MAX_ENTRIES);
   localparam logic [6:0] GW_C = 7'(GLYPH_WORDS);

   localparam int CW = sct_pkg::COUNT_W;

   logic [sct_pkg::CODE_W-1:0] code_mem_ff [MAX_ENTRIES];
   logic [sct_pkg::CODE_W-1:0] rdata_ff;
   logic [sct_pkg::CODE_W-1:0] key_ff;
   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              lo_ff, hi_ff, mid_ff;
   logic [CW-1:0]              lo_in, hi_in, mid_in;
   sct_pkg::rsp_type           result_ff, result_in;

   logic [CW-1:0]   eff_count;
   logic [CW-1:0]   init_hi;
   logic [CW-1:0]   mid_p1, mid_m1;
   logic [CW:0]     bound_sum;
   logic            go_up;
   logic            load_in_range;
   logic [XW-1:0]   idx_ext;
   logic [XW-1:0]   addr_ext;
   logic [AW-1:0]   rd_addr;
   logic [17:0]     offset_prod;

   // Entry count register: user must write it only while the block is idle, unenforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   assign eff_count = (count_ff > CLAMP_C) ? CLAMP_C : count_ff;
   assign init_hi   = eff_count - CW'(1);

   assign idx_ext       = XW'(req_data.entry_index);
   assign load_in_range = idx_ext < MAX_C;

   // One probe step: compare the fetched entry and narrow the range.
   assign mid_p1 = mid_ff + CW'(1);
   assign mid_m1 = mid_ff - CW'(1);
   assign go_up  = rdata_ff < key_ff;

   always_comb begin
      if (cmd.init_search) begin
         lo_in = '0;
         hi_in = init_hi;
      end else if (go_up) begin
         lo_in = mid_p1;
         hi_in = hi_ff;
      end else begin
         lo_in = lo_ff;
         hi_in = mid_m1;
      end
      bound_sum = {1'b0, lo_in} + {1'b0, hi_in};
      mid_in    = bound_sum[CW:1];
   end

   assign status.is_load     = req_data.mode == sct_pkg::MODE_LOAD;
   assign status.is_search   = req_data.mode == sct_pkg::MODE_SEARCH;
   assign status.is_read     = req_data.mode == sct_pkg::MODE_READ;
   assign status.table_empty = eff_count == '0;
   assign status.read_oor    = {1'b0, req_data.entry_index} >= eff_count;
   assign status.hit         = rdata_ff == key_ff;
   assign status.more        = (rdata_ff != key_ff) &&
                               (go_up ? (mid_p1 <= hi_ff)
                                      : ((mid_ff != '0) && (lo_ff <= mid_m1)));

   always_ff @(posedge clock) begin
      if (cmd.init_search || cmd.step_search) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= mid_in;
      end
      if (cmd.init_search) begin
         key_ff <= req_data.search_code;
      end
   end

   // The next probe address follows the compare in the same cycle.
   always_comb begin
      if (cmd.init_search || cmd.step_search) begin
         addr_ext = XW'(mid_in);
      end else begin
         addr_ext = idx_ext;
      end
      rd_addr = addr_ext[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.table_write && load_in_range) begin
         code_mem_ff[idx_ext[AW-1:0]] <= req_data.entry_code;
      end
      rdata_ff <= code_mem_ff[rd_addr];
   end

   assign offset_prod = 18'(mid_ff) * 18'(GW_C);

   always_comb begin
      result_in = '0;
      case (cmd.res_kind)
         sct_pkg::RES_ZERO: result_in = '0;
         sct_pkg::RES_OOR:  result_in.out_of_range = 1'b1;
         sct_pkg::RES_READ: result_in.read_code = rdata_ff;
         sct_pkg::RES_HIT: begin
            result_in.found          = 1'b1;
            result_in.match_position = mid_ff[sct_pkg::INDEX_W-1:0];
            result_in.bitmap_offset  = offset_prod[sct_pkg::OFFS_W-1:0];
         end
         default: result_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_data = result_ff;

endmodule

`default_nettype wire

// File: src/sct_ctrl.sv
// Controller state machine of the sorted code table search.
`default_nettype none

module sct_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire sct_pkg::status_type status,
   output sct_pkg::cmd_type         cmd,
   output logic                     busy,
   output logic                     rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_READ   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.res_kind = sct_pkg::RES_ZERO;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.is_search) begin
                  if (status.table_empty) begin
                     cmd.res_load = 1'b1;
                     rsp_valid_in = 1'b1;
                  end else begin
                     cmd.init_search = 1'b1;
                     state_in        = ST_SEARCH;
                  end
               end else if (status.is_read) begin
                  if (status.read_oor) begin
                     cmd.res_load = 1'b1;
                     cmd.res_kind = sct_pkg::RES_OOR;
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  cmd.table_write = status.is_load;
                  cmd.res_load    = 1'b1;
                  rsp_valid_in    = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (status.hit) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = sct_pkg::RES_HIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (!status.more) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.step_search = 1'b1;
            end
         end
         ST_READ: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = sct_pkg::RES_READ;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // A result only follows an accepted item or the last cycle of a multi-cycle item.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(accept) || $past(state_ff != ST_IDLE)))
      else $error("result strobe without a transfer in progress");

   // A table read always completes in the following cycle.
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("read did not complete after one cycle");

   // Leaving the search state always comes with a result.
   a_search_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("search ended without a result");

   // A search on a non-empty table enters the probe loop.
   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && status.is_search && !status.table_empty) |=> (state_ff == ST_SEARCH))
      else $error("search did not start");
`endif

endmodule

`default_nettype wire

// File: src/sorted_code_table_search_top.sv
// Top level of the sorted code table search block.
`default_nettype none

// The block keeps an ascending table of character codes and serves three kinds of
// items, chosen by req_data.mode: a load writes entry_code at entry_index, a search
// binary-searches the first entry_count entries for search_code, and a read returns
// the stored code at entry_index. An item transfers at a rising edge where start is
// high and busy is low. Each item gives exactly one result on rsp_data, marked by
// rsp_valid for a single cycle; the receiver cannot stall it, so it must take the
// result in that cycle. Loads, mode 3 items, searches of an empty table and
// out-of-range reads never raise busy: their result appears the cycle after the
// transfer and another item may transfer in that same cycle. A read in range keeps
// busy high while the controller is in its read state, and its result is registered
// as that state ends. A search keeps busy high while it probes the table and delivers
// its result right after the last probe: with n valid entries that is at most
// floor(log2(n)) + 1 probes, 11 for a full table of 1024 entries. The
// probe rate is set by the single read port of the code memory, whose registered
// output feeds the compare that picks the next probe address in the same cycle.
// The entry count is written through csr_wr_en and csr_wr_data and must only be
// changed while the block is idle; counts above MAX_ENTRIES act as MAX_ENTRIES.
// Table entries are not cleared by reset, so searches and reads must only touch
// entries that have been loaded. A hit reports the position and a bitmap offset of
// position times GLYPH_WORDS, truncated to the port width.

module sorted_code_table_search_top #(
   parameter int MAX_ENTRIES = 1024,
   parameter int GLYPH_WORDS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire sct_pkg::req_type            req_data,
   output logic                             rsp_valid,
   output sct_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [sct_pkg::COUNT_W-1:0] csr_wr_data
);

   // Commands and status between the controller and the datapath.
   sct_pkg::cmd_type    cmd;
   sct_pkg::status_type status;

   // The controller sequences each transfer and times the result strobe.
   sct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the code memory, the entry count, the search bounds
   // and the result register that drives rsp_data.
   sct_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .GLYPH_WORDS (GLYPH_WORDS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// File: bench/tb_sorted_code_table_search_top.sv
// Self-checking testbench for the sorted code table search block.
`default_nettype none

// The bench drives load, search, read and spare-mode items into the block through the
// start/busy handshake and checks every result against its own model of the code table.
// A short table of hand-written items comes first: the empty table, the extremes of
// every field, the spare mode, a table made unsorted on purpose and a count that covers
// only part of the loaded entries. Random phases follow. Each phase writes a new entry
// count while the block is idle, loads a fresh ascending table that covers every entry
// below that count, and then mixes searches for stored codes, near misses, random codes,
// reads inside and outside the valid range, stray loads and spare-mode items. Searches
// and reads never reach an entry that was not loaded, since the table is not cleared by
// reset. Phases whose count reaches the full table size, oversized counts included, only
// use the entries on the probe paths toward a few chosen positions, among them both
// ends of the table, and the oversized ones reuse the paths loaded before. There the
// bench searches only for stored codes, reads only stored entries and reloads them with
// codes that keep the table ascending, so every probe stays on a loaded path.

module tb_sorted_code_table_search_top;

   localparam int MAX_ENTRIES = 1024;
   localparam int GLYPH_WORDS = 16;

   localparam int MODE_W  = sct_pkg::MODE_W;
   localparam int INDEX_W = sct_pkg::INDEX_W;
   localparam int CODE_W  = sct_pkg::CODE_W;
   localparam int COUNT_W = sct_pkg::COUNT_W;
   localparam int OFFS_W  = sct_pkg::OFFS_W;

   // The one mode that the package leaves unnamed; the block answers it with an all-zero result.
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam logic [CODE_W-1:0] CODE_MAX  = 21'h10FFFF;
   localparam int                CODE_SPAN = 1114112;

   localparam int NUM_PHASES    = 12;
   localparam int OPS_PER_PHASE = 32;
   localparam int SPARSE_PATHS  = 14;
   localparam int SETTLE_CYCLES = 16;
   // The limit sits well above the slowest correct run, even with every phase at its
   // largest random size, every gap at its longest and every search at eleven probes.
   localparam int CYCLE_LIMIT   = 600000;

   localparam sct_pkg::rsp_type NO_RESULT = '0;

   typedef enum logic {
      ROW_ITEM,
      ROW_COUNT
   } row_kind_type;

   // One line of the hand-written table: either an item or a new entry count. Where the
   // result is obvious it is typed in; otherwise the table model supplies it.
   typedef struct {
      row_kind_type         kind;
      sct_pkg::req_type     item;
      logic [COUNT_W-1:0]   count;
      bit                   has_known;
      sct_pkg::rsp_type     known;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   sct_pkg::req_type   req_data;
   logic               rsp_valid;
   sct_pkg::rsp_type   rsp_data;
   logic               csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   // The bench's own copy of the block's state.
   logic [CODE_W-1:0]  code_mem [MAX_ENTRIES];
   logic [COUNT_W-1:0] count_reg;

   // Positions loaded for the full-size phases.
   bit                 on_path [MAX_ENTRIES];
   int                 sparse_list [$];

   sct_pkg::rsp_type   awaited_responses [$];
   directed_row_type   directed_rows [$];
   int                 mismatch_count;
   int                 steady_left;

   sorted_code_table_search_top #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .GLYPH_WORDS (GLYPH_WORDS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Counts above the table size behave as a full table.
   function automatic int active_entries();
      return (count_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_reg);
   endfunction

   // Marks every position that a search over the full table probes on its way to the
   // target position.
   function automatic void mark_path(input int target);
      int lo;
      int hi;
      int mid;
      lo  = 0;
      hi  = MAX_ENTRIES - 1;
      mid = -1;
      while (lo <= hi && mid != target) begin
         mid          = (lo + hi) / 2;
         on_path[mid] = 1'b1;
         if (mid < target) begin
            lo = mid + 1;
         end else if (mid > target) begin
            hi = mid - 1;
         end
      end
   endfunction

   // Computes the result of one item and applies a load to the table copy. The search
   // probes the midpoint of an inclusive range and stops at the first probe that
   // matches, so an unsorted table gives the same answer as the block's probe order.
   function automatic sct_pkg::rsp_type table_response(input sct_pkg::req_type item);
      sct_pkg::rsp_type res;
      int      n;
      int      lo;
      int      hi;
      int      mid;
      res = NO_RESULT;
      n   = active_entries();
      case (item.mode)
         sct_pkg::MODE_LOAD: begin
            code_mem[item.entry_index] = item.entry_code;
         end
         sct_pkg::MODE_SEARCH: begin
            lo = 0;
            hi = n - 1;
            while (lo <= hi && !res.found) begin
               mid = (lo + hi) / 2;
               if (code_mem[mid] == item.search_code) begin
                  res.found          = 1'b1;
                  res.match_position = INDEX_W'(mid);
                  res.bitmap_offset  = OFFS_W'(mid * GLYPH_WORDS);
               end else if (code_mem[mid] < item.search_code) begin
                  lo = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
         end
         sct_pkg::MODE_READ: begin
            if (int'(item.entry_index) < n) begin
               res.read_code = code_mem[item.entry_index];
            end else begin
               res.out_of_range = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic sct_pkg::rsp_type outcome(input logic found, input int pos,
                                                input int offs,
                                                input logic [CODE_W-1:0] code,
                                                input logic oor);
      sct_pkg::rsp_type res;
      res.found          = found;
      res.match_position = INDEX_W'(pos);
      res.bitmap_offset  = OFFS_W'(offs);
      res.read_code      = code;
      res.out_of_range   = oor;
      return res;
   endfunction

   function automatic directed_row_type item_row(input logic [MODE_W-1:0] mode,
                                                 input int idx,
                                                 input logic [CODE_W-1:0] ecode,
                                                 input logic [CODE_W-1:0] scode);
      directed_row_type row;
      row.kind                   = ROW_ITEM;
      row.item.mode              = mode;
      row.item.entry_index       = INDEX_W'(idx);
      row.item.entry_code        = ecode;
      row.item.search_code       = scode;
      row.count                  = '0;
      row.has_known              = 1'b0;
      row.known                  = NO_RESULT;
      return row;
   endfunction

   function automatic directed_row_type known_row(input logic [MODE_W-1:0] mode,
                                                  input int idx,
                                                  input logic [CODE_W-1:0] ecode,
                                                  input logic [CODE_W-1:0] scode,
                                                  input sct_pkg::rsp_type known);
      directed_row_type row;
      row           = item_row(mode, idx, ecode, scode);
      row.has_known = 1'b1;
      row.known     = known;
      return row;
   endfunction

   function automatic directed_row_type count_row(input int value);
      directed_row_type row;
      row       = item_row(MODE_SPARE, 0, '0, '0);
      row.kind  = ROW_COUNT;
      row.count = COUNT_W'(value);
      return row;
   endfunction

   // Presents one item and returns at the edge where it transfers. The gap before the
   // item is drawn per item, with occasional stretches of back-to-back items. Start is
   // given exactly one assignment per time step, so an item that follows directly
   // keeps start high and only the payload changes.
   task automatic send_item(input sct_pkg::req_type item, input bit has_known,
                            input sct_pkg::rsp_type known);
      int               gap;
      sct_pkg::rsp_type predicted;
      if (steady_left > 0) begin
         gap = 0;
         steady_left--;
      end else if ($urandom_range(0, 15) == 0) begin
         gap         = 0;
         steady_left = $urandom_range(8, 30);
      end else begin
         gap = $urandom_range(0, 4);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predicted = table_response(item);
      awaited_responses.push_back(has_known ? known : predicted);
   endtask

   // The count may only change while the block is idle. Every item gives a result, so
   // the block is idle once nothing is awaited any more.
   task automatic write_count(input logic [COUNT_W-1:0] value);
      start <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      count_reg  = value;
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("Mismatch in %s at %0t: expected %0h, got %0h", what, $time, want, got);
      end
   endtask

   // Results cannot be held off, so every strobe is checked at the edge that ends it.
   always @(posedge clock) begin
      sct_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_responses.size() == 0) begin
            note_mismatch("result with nothing awaited", '0, 64'(rsp_data));
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_data.found !== want.found)
               note_mismatch("found", 64'(want.found), 64'(rsp_data.found));
            if (rsp_data.match_position !== want.match_position)
               note_mismatch("match_position", 64'(want.match_position),
                             64'(rsp_data.match_position));
            if (rsp_data.bitmap_offset !== want.bitmap_offset)
               note_mismatch("bitmap_offset", 64'(want.bitmap_offset),
                             64'(rsp_data.bitmap_offset));
            if (rsp_data.read_code !== want.read_code)
               note_mismatch("read_code", 64'(want.read_code), 64'(rsp_data.read_code));
            if (rsp_data.out_of_range !== want.out_of_range)
               note_mismatch("out_of_range", 64'(want.out_of_range),
                             64'(rsp_data.out_of_range));
         end
      end
   end

   // A hung handshake or a lost result ends the run here.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int                 p;
      int                 k;
      int                 n;
      int                 slot;
      int                 sel;
      int                 idx;
      int                 probe;
      bit                 sparse;
      sct_pkg::req_type   item;
      logic [COUNT_W-1:0] count_value;

      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      count_reg      = '0;
      mismatch_count = 0;
      steady_left    = 0;

      // Hand-written items. The count starts at zero after reset, so the first items
      // see an empty table.
      directed_rows.push_back(known_row(sct_pkg::MODE_SEARCH, 0, '0, '0, NO_RESULT));
      directed_rows.push_back(known_row(sct_pkg::MODE_SEARCH, 1023, CODE_MAX, CODE_MAX,
                                        NO_RESULT));
      directed_rows.push_back(known_row(sct_pkg::MODE_READ, 0, '0, '0,
                                        outcome(1'b0, 0, 0, '0, 1'b1)));
      directed_rows.push_back(known_row(sct_pkg::MODE_READ, 1023, CODE_MAX, CODE_MAX,
                                        outcome(1'b0, 0, 0, '0, 1'b1)));
      directed_rows.push_back(known_row(MODE_SPARE, 1023, CODE_MAX, CODE_MAX, NO_RESULT));
      // Load four ascending codes that include both ends of the code range, plus the
      // last table position.
      directed_rows.push_back(known_row(sct_pkg::MODE_LOAD, 0, 21'h000000, CODE_MAX,
                                        NO_RESULT));
      directed_rows.push_back(known_row(sct_pkg::MODE_LOAD, 1, 21'h000005, '0, NO_RESULT));
      directed_rows.push_back(known_row(sct_pkg::MODE_LOAD, 2, 21'h010000, '0, NO_RESULT));
      directed_rows.push_back(known_row(sct_pkg::MODE_LOAD, 3, CODE_MAX, '0, NO_RESULT));
      directed_rows.push_back(known_row(sct_pkg::MODE_LOAD, 1023, 21'h0AAAAA, 21'h155555,
                                        NO_RESULT));
      directed_rows.push_back(count_row(4));
      directed_rows.push_back(known_row(sct_pkg::MODE_SEARCH, 0, '0, 21'h000000,
                                        outcome(1'b1, 0, 0, '0, 1'b0)));
      directed_rows.push_back(known_row(sct_pkg::MODE_SEARCH, 0, '0, CODE_MAX,
                                        outcome(1'b1, 3, 48, '0, 1'b0)));
      directed_rows.push_back(item_row(sct_pkg::MODE_SEARCH, 0, '0, 21'h000005));
      directed_rows.push_back(item_row(sct_pkg::MODE_SEARCH, 0, '0, 21'h000006));
      directed_rows.push_back(known_row(sct_pkg::MODE_READ, 3, '0, '0,
                                        outcome(1'b0, 0, 0, CODE_MAX, 1'b0)));
      directed_rows.push_back(known_row(sct_pkg::MODE_READ, 4, '0, '0,
                                        outcome(1'b0, 0, 0, '0, 1'b1)));
      directed_rows.push_back(known_row(sct_pkg::MODE_READ, 0, '0, '0, NO_RESULT));
      // Break the ordering: the probe at position 1 now sends the search the wrong way.
      directed_rows.push_back(item_row(sct_pkg::MODE_LOAD, 1, 21'h0FFFFF, '0));
      directed_rows.push_back(item_row(sct_pkg::MODE_SEARCH, 0, '0, 21'h010000));
      directed_rows.push_back(item_row(sct_pkg::MODE_SEARCH, 0, '0, 21'h0FFFFF));
      // A count of one hides the rest of the loaded entries.
      directed_rows.push_back(count_row(1));
      directed_rows.push_back(item_row(sct_pkg::MODE_SEARCH, 0, '0, CODE_MAX));
      directed_rows.push_back(item_row(sct_pkg::MODE_SEARCH, 0, '0, 21'h000000));
      directed_rows.push_back(known_row(sct_pkg::MODE_READ, 1, '0, '0,
                                        outcome(1'b0, 0, 0, '0, 1'b1)));

      // Probe paths for the full-size phases: both ends of the table, the upper end taking
      // one of the longest searches, and a few random positions.
      mark_path(0);
      mark_path(MAX_ENTRIES - 1);
      for (k = 0; k < SPARSE_PATHS; k++) begin
         mark_path($urandom_range(0, MAX_ENTRIES - 1));
      end
      for (k = 0; k < MAX_ENTRIES; k++) begin
         if (on_path[k]) sparse_list.push_back(k);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_COUNT) begin
            write_count(directed_rows[r].count);
         end else begin
            send_item(directed_rows[r].item, directed_rows[r].has_known,
                      directed_rows[r].known);
         end
      end

      // Random phases. The probe paths are loaded under the full-size count, and the
      // oversized counts that follow reuse them as they stand.
      for (p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: count_value = 11'd1;
            1: count_value = 11'd2;
            2: count_value = 11'd3;
            3: count_value = COUNT_W'(MAX_ENTRIES);
            4: count_value = 11'd2047;
            5: count_value = COUNT_W'(MAX_ENTRIES + 1);
            6: count_value = 11'd0;
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  count_value = COUNT_W'($urandom_range(41, 300));
               end else begin
                  count_value = COUNT_W'($urandom_range(1, 40));
               end
            end
         endcase
         write_count(count_value);
         n      = active_entries();
         sparse = (n == MAX_ENTRIES);
         slot   = (n > 0) ? CODE_SPAN / n : CODE_SPAN;

         if (sparse) begin
            // Ascending codes on the probe paths, one slot of the code range per position.
            if (count_value <= MAX_ENTRIES) begin
               foreach (sparse_list[s]) begin
                  item.mode        = sct_pkg::MODE_LOAD;
                  item.entry_index = INDEX_W'(sparse_list[s]);
                  item.entry_code  = CODE_W'(sparse_list[s] * slot +
                                             $urandom_range(0, slot - 1));
                  item.search_code = CODE_W'($urandom_range(0, CODE_MAX));
                  send_item(item, 1'b0, NO_RESULT);
               end
            end
         end else if (n > 0) begin
            // A fresh strictly ascending table: one code per slot of the code range.
            for (k = 0; k < n; k++) begin
               item.mode        = sct_pkg::MODE_LOAD;
               item.entry_index = INDEX_W'(k);
               item.entry_code  = CODE_W'(k * slot + $urandom_range(0, slot - 1));
               item.search_code = CODE_W'($urandom_range(0, CODE_MAX));
               send_item(item, 1'b0, NO_RESULT);
            end
         end

         for (k = 0; k < OPS_PER_PHASE; k++) begin
            sel              = $urandom_range(0, 99);
            idx              = (n > 0) ? $urandom_range(0, n - 1) : 0;
            item.mode        = sct_pkg::MODE_SEARCH;
            item.entry_index = INDEX_W'($urandom_range(0, MAX_ENTRIES - 1));
            item.entry_code  = CODE_W'($urandom_range(0, CODE_MAX));
            item.search_code = CODE_W'($urandom_range(0, CODE_MAX));
            if (sparse) begin
               // Only loaded positions are touched, and a reload keeps its code inside
               // the position's own slot so the order holds.
               idx              = sparse_list[$urandom_range(0, sparse_list.size() - 1)];
               item.entry_index = INDEX_W'(idx);
               if (sel < 55) begin
                  item.search_code = code_mem[idx];
               end else if (sel < 80) begin
                  item.mode = sct_pkg::MODE_READ;
               end else if (sel < 93) begin
                  item.mode       = sct_pkg::MODE_LOAD;
                  item.entry_code = CODE_W'(idx * slot + $urandom_range(0, slot - 1));
               end else begin
                  item.mode = MODE_SPARE;
               end
            end else if (sel < 40) begin
               // A code that is stored, so most of these searches hit.
               if (n > 0) item.search_code = code_mem[idx];
            end else if (sel < 55) begin
               // One step beside a stored code, to catch off-by-one compares.
               if (n > 0) begin
                  probe = int'(code_mem[idx]);
                  if (probe == int'(CODE_MAX) || ($urandom_range(0, 1) == 0 && probe > 0)) begin
                     probe = probe - 1;
                  end else begin
                     probe = probe + 1;
                  end
                  item.search_code = CODE_W'(probe);
               end
            end else if (sel < 70) begin
               // A random code, left as drawn.
            end else if (sel < 85) begin
               item.mode = sct_pkg::MODE_READ;
               if (n > 0 && $urandom_range(0, 1) == 0) item.entry_index = INDEX_W'(idx);
            end else if (sel < 93) begin
               // A stray load; inside the valid range it may leave the table unsorted.
               item.mode = sct_pkg::MODE_LOAD;
            end else begin
               item.mode = MODE_SPARE;
            end
            send_item(item, 1'b0, NO_RESULT);
         end
      end

      start <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
